// ===== src/sadt_pkg.sv =====
package sadt_pkg;

	localparam int unsigned LenWidth = 24;
	localparam int unsigned ByteWidth = 8;

	typedef logic [ByteWidth-1:0] byte_t;
	typedef logic [LenWidth-1:0] len_t;

	typedef enum logic [2:0] {
		KIND_TINY   = 3'd0,
		KIND_SHORT  = 3'd1,
		KIND_MEDIUM = 3'd2,
		KIND_LONG   = 3'd3,
		KIND_CTRL   = 3'd4
	} kind_t;

	typedef enum logic [1:0] {
		PH_HEADER = 2'd0,
		PH_LENGTH = 2'd1,
		PH_DATA   = 2'd2
	} phase_t;

	typedef struct packed {
		kind_t atom_kind;
		logic  is_header;
		logic  byte_flag;
		logic  signed_flag;
		len_t  data_length;
		byte_t value;
		logic  last;
	} result_t;

endpackage

// ===== src/sadt_step.sv =====
module sadt_step (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             step,
	input  sadt_pkg::byte_t  stream_byte,
	output logic             res_valid,
	output sadt_pkg::result_t res
);
	import sadt_pkg::*;

	phase_t     phase_q, phase_d;
	len_t       remaining_q, remaining_d;
	logic [1:0] len_left_q, len_left_d;
	kind_t      kind_q, kind_d;
	logic [1:0] flags_q, flags_d;

	len_t       rem_shift;
	len_t       rem_dec;
	logic [1:0] len_left_dec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HEADER;
			remaining_q <= '0;
			len_left_q  <= '0;
			kind_q      <= KIND_TINY;
			flags_q     <= '0;
		end else if (step) begin
			phase_q     <= phase_d;
			remaining_q <= remaining_d;
			len_left_q  <= len_left_d;
			kind_q      <= kind_d;
			flags_q     <= flags_d;
		end
	end

	assign rem_shift    = {remaining_q[LenWidth-ByteWidth-1:0], stream_byte};
	assign rem_dec      = remaining_q - len_t'(1);
	assign len_left_dec = len_left_q - 2'd1;

	always_comb begin
		phase_d     = phase_q;
		remaining_d = remaining_q;
		len_left_d  = len_left_q;
		kind_d      = kind_q;
		flags_d     = flags_q;
		res_valid   = 1'b0;
		res         = '{atom_kind: kind_q, is_header: 1'b1, byte_flag: flags_q[1],
			signed_flag: flags_q[0], data_length: '0, value: '0, last: 1'b0};

		unique case (phase_q)
			PH_LENGTH: begin
				remaining_d = rem_shift;
				len_left_d  = len_left_dec;
				if (len_left_dec == 2'd0) begin
					res_valid       = 1'b1;
					res.data_length = rem_shift;
					res.last        = (rem_shift == '0);
					phase_d         = (rem_shift == '0) ? PH_HEADER : PH_DATA;
				end
			end
			PH_DATA: begin
				remaining_d     = rem_dec;
				res_valid       = 1'b1;
				res.is_header   = 1'b0;
				res.data_length = rem_dec;
				res.value       = stream_byte;
				res.last        = (rem_dec == '0);
				if (rem_dec == '0) begin
					phase_d = PH_HEADER;
				end
			end
			default: begin
				phase_d = PH_HEADER;
				priority casez (stream_byte)
					8'b0???????: begin
						res_valid       = 1'b1;
						res.atom_kind   = KIND_TINY;
						res.byte_flag   = 1'b0;
						res.signed_flag = stream_byte[6];
						res.value       = {{2{stream_byte[6] & stream_byte[5]}},
							stream_byte[5:0]};
						res.last        = 1'b1;
					end
					8'b10??????: begin
						kind_d          = KIND_SHORT;
						flags_d         = stream_byte[5:4];
						remaining_d     = len_t'(stream_byte[3:0]);
						res_valid       = 1'b1;
						res.atom_kind   = KIND_SHORT;
						res.byte_flag   = stream_byte[5];
						res.signed_flag = stream_byte[4];
						res.data_length = len_t'(stream_byte[3:0]);
						res.last        = (stream_byte[3:0] == 4'd0);
						phase_d         = (stream_byte[3:0] == 4'd0) ? PH_HEADER : PH_DATA;
					end
					8'b110?????: begin
						kind_d      = KIND_MEDIUM;
						flags_d     = stream_byte[4:3];
						remaining_d = len_t'(stream_byte[2:0]);
						len_left_d  = 2'd1;
						phase_d     = PH_LENGTH;
					end
					8'b1110????: begin
						kind_d      = KIND_LONG;
						flags_d     = stream_byte[1:0];
						remaining_d = '0;
						len_left_d  = 2'd3;
						phase_d     = PH_LENGTH;
					end
					default: begin
						res_valid       = 1'b1;
						res.atom_kind   = KIND_CTRL;
						res.byte_flag   = 1'b0;
						res.signed_flag = 1'b0;
						res.value       = stream_byte;
						res.last        = 1'b1;
					end
				endcase
			end
		endcase
	end

endmodule

// ===== src/storage_atom_token_decoder_top.sv =====
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid / in_ready  | stream_byte
// out     | output    | out_valid / out_ready| atom_kind, is_header, byte_flag, signed_flag,
//         |           |                      | data_length, value, last
// An accepted byte passes through the input register and then the decode logic; a byte that
// yields a result lands in the result register. One item is accepted every cycle
// as long as the result register is free or being emptied in the same cycle.
// Reset clears the parser state to expect a header byte and empties both registers.
// A stalled output holds its result and the input register, which then stalls the input.
module storage_atom_token_decoder_top (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  sadt_pkg::byte_t       stream_byte,
	output logic                  out_valid,
	input  logic                  out_ready,
	output sadt_pkg::kind_t       atom_kind,
	output logic                  is_header,
	output logic                  byte_flag,
	output logic                  signed_flag,
	output sadt_pkg::len_t        data_length,
	output sadt_pkg::byte_t       value,
	output logic                  last
);
	import sadt_pkg::*;

	logic    valid_s1;
	byte_t   byte_s1;
	logic    valid_s2;
	result_t res_s2;
	logic    advance;
	logic    step_valid;
	result_t step_res;

	assign advance  = valid_s1 && (!valid_s2 || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= stream_byte;
		end
	end

	sadt_step u_step (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (advance),
		.stream_byte(byte_s1),
		.res_valid  (step_valid),
		.res        (step_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= step_valid;
		end else if (out_ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && step_valid) begin
			res_s2 <= step_res;
		end
	end

	assign out_valid   = valid_s2;
	assign atom_kind   = res_s2.atom_kind;
	assign is_header   = res_s2.is_header;
	assign byte_flag   = res_s2.byte_flag;
	assign signed_flag = res_s2.signed_flag;
	assign data_length = res_s2.data_length;
	assign value       = res_s2.value;
	assign last        = res_s2.last;

endmodule

// ===== tb/sv/storage_atom_token_decoder_top_tb.sv =====
`timescale 1ns / 1ps

module storage_atom_token_decoder_top_tb;
	import sadt_pkg::*;

	typedef struct {
		byte_t   stim;
		bit      typed;
		result_t res;
	} dir_row_t;

	logic    clk = 1'b0;
	logic    arst_n;
	logic    in_valid;
	logic    in_ready;
	byte_t   stream_byte;
	logic    out_valid;
	logic    out_ready;
	kind_t   atom_kind;
	logic    is_header;
	logic    byte_flag;
	logic    signed_flag;
	len_t    data_length;
	byte_t   value;
	logic    last;

	result_t atom_results_due[$];
	int      mismatch_count = 0;
	int      bytes_fed = 0;
	int      send_idle_pct = 0;
	int      recv_stall_pct = 0;
	int      hold_requests = 0;
	int      holds_served = 0;
	int      hold_left = 0;

	phase_t      pr_phase = PH_HEADER;
	len_t        pr_left = '0;
	logic [1:0]  pr_len_bytes = '0;
	kind_t       pr_kind = KIND_TINY;
	logic [1:0]  pr_flags = '0;

	storage_atom_token_decoder_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.stream_byte(stream_byte),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.atom_kind(atom_kind),
		.is_header(is_header),
		.byte_flag(byte_flag),
		.signed_flag(signed_flag),
		.data_length(data_length),
		.value(value),
		.last(last)
	);

	always #5 clk = ~clk;

	// Advances the parser state by one stream byte and returns 1 when the byte yields a result.
	function automatic bit parse_byte(input byte_t b, output result_t r);
		bit hdr_ready;
		bit got;
		hdr_ready = 1'b0;
		got = 1'b0;
		r = '0;
		case (pr_phase)
			PH_LENGTH: begin
				pr_left = {pr_left[15:0], b};
				pr_len_bytes = pr_len_bytes - 2'd1;
				hdr_ready = (pr_len_bytes == 2'd0);
			end
			PH_DATA: begin
				pr_left = pr_left - 1'b1;
				r = '{pr_kind, 1'b0, pr_flags[1], pr_flags[0], pr_left, b, pr_left == '0};
				got = 1'b1;
				if (pr_left == '0) pr_phase = PH_HEADER;
			end
			default: begin
				pr_phase = PH_HEADER;
				if (!b[7]) begin
					r = '{KIND_TINY, 1'b1, 1'b0, b[6], '0,
						(b[6] && b[5]) ? {3'b111, b[4:0]} : {2'b00, b[5:0]}, 1'b1};
					got = 1'b1;
				end else if (b[7:6] == 2'b10) begin
					pr_kind = KIND_SHORT;
					pr_flags = b[5:4];
					pr_left = len_t'(b[3:0]);
					hdr_ready = 1'b1;
				end else if (b[7:5] == 3'b110) begin
					pr_kind = KIND_MEDIUM;
					pr_flags = b[4:3];
					pr_left = len_t'(b[2:0]);
					pr_len_bytes = 2'd1;
					pr_phase = PH_LENGTH;
				end else if (b[7:4] == 4'b1110) begin
					pr_kind = KIND_LONG;
					pr_flags = b[1:0];
					pr_left = '0;
					pr_len_bytes = 2'd3;
					pr_phase = PH_LENGTH;
				end else begin
					r = '{KIND_CTRL, 1'b1, 1'b0, 1'b0, '0, b, 1'b1};
					got = 1'b1;
				end
			end
		endcase
		if (hdr_ready) begin
			r = '{pr_kind, 1'b1, pr_flags[1], pr_flags[0], pr_left, 8'h00, pr_left == '0};
			got = 1'b1;
			pr_phase = (pr_left == '0) ? PH_HEADER : PH_DATA;
		end
		return got;
	endfunction

	function automatic result_t whole_atom(kind_t k, logic sf, byte_t v);
		return '{k, 1'b1, 1'b0, sf, '0, v, 1'b1};
	endfunction

	task automatic report_error(string msg);
		mismatch_count++;
		if (mismatch_count <= 50) $display("MISMATCH at %0t: %s", $time, msg);
	endtask

	task automatic check_result();
		result_t seen;
		result_t want;
		seen = '{atom_kind, is_header, byte_flag, signed_flag, data_length, value, last};
		if (atom_results_due.size() == 0) begin
			report_error($sformatf("result %h with none pending", seen));
			return;
		end
		want = atom_results_due.pop_front();
		if (seen.atom_kind !== want.atom_kind)
			report_error($sformatf("atom_kind got %0d want %0d", seen.atom_kind, want.atom_kind));
		if (seen.is_header !== want.is_header)
			report_error($sformatf("is_header got %b want %b", seen.is_header, want.is_header));
		if (seen.byte_flag !== want.byte_flag)
			report_error($sformatf("byte_flag got %b want %b", seen.byte_flag, want.byte_flag));
		if (seen.signed_flag !== want.signed_flag)
			report_error($sformatf("signed_flag got %b want %b", seen.signed_flag,
				want.signed_flag));
		if (seen.data_length !== want.data_length)
			report_error($sformatf("data_length got %h want %h", seen.data_length,
				want.data_length));
		if (seen.value !== want.value)
			report_error($sformatf("value got %h want %h", seen.value, want.value));
		if (seen.last !== want.last)
			report_error($sformatf("last got %b want %b", seen.last, want.last));
	endtask

	// Called just after a rising edge; returns just after the edge that accepts the item.
	task automatic feed_byte(byte_t b, bit typed = 1'b0, result_t typed_res = '0);
		result_t r;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		stream_byte <= b;
		do @(posedge clk); while (!in_ready);
		bytes_fed++;
		if (parse_byte(b, r)) atom_results_due.push_back(typed ? typed_res : r);
	endtask

	task automatic feed_random_atoms(int n);
		int          stop_at;
		int          pick;
		int          shape;
		int unsigned len;
		logic [1:0]  fl;
		byte_t       b;
		stop_at = bytes_fed + n;
		while (bytes_fed < stop_at) begin
			pick = $urandom_range(99);
			fl = 2'($urandom);
			len = 0;
			if (pick < 15) begin
				feed_byte(8'($urandom_range(127)));
			end else if (pick < 25) begin
				feed_byte({4'hF, 4'($urandom)});
			end else if (pick < 33) begin
				// Loose bytes, kept away from long headers so that no atom runs on for megabytes.
				b = 8'($urandom);
				if (b[7:4] == 4'hE) b[4] = 1'b1;
				if (b[7:5] == 3'b110) b[2:0] = 3'b000;
				feed_byte(b);
			end else begin
				shape = $urandom_range(2);
				case (shape)
					0: begin
						len = $urandom_range(15);
						feed_byte({2'b10, fl, 4'(len)});
					end
					1: begin
						len = ($urandom_range(19) == 0) ? $urandom_range(300) : $urandom_range(24);
						feed_byte({3'b110, fl, 3'(len >> 8)});
						feed_byte(8'(len));
					end
					default: begin
						len = ($urandom_range(19) == 0) ? $urandom_range(600) : $urandom_range(24);
						feed_byte({4'hE, 2'($urandom), fl});
						feed_byte(8'(len >> 16));
						feed_byte(8'(len >> 8));
						feed_byte(8'(len));
					end
				endcase
				repeat (len) feed_byte(8'($urandom));
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) check_result();
		if (holds_served != hold_requests) begin
			holds_served = hold_requests;
			hold_left = 200;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	initial begin
		#10_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		dir_row_t rows[$];
		arst_n = 1'b0;
		in_valid = 1'b0;
		stream_byte = '0;
		out_ready = 1'b0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		rows = '{
			'{8'h00, 1'b1, whole_atom(KIND_TINY, 1'b0, 8'h00)},
			'{8'h3F, 1'b1, whole_atom(KIND_TINY, 1'b0, 8'h3F)},
			'{8'h40, 1'b1, whole_atom(KIND_TINY, 1'b1, 8'h00)},
			'{8'h5F, 1'b1, whole_atom(KIND_TINY, 1'b1, 8'h1F)},
			'{8'h60, 1'b1, whole_atom(KIND_TINY, 1'b1, 8'hE0)},
			'{8'h7F, 1'b1, whole_atom(KIND_TINY, 1'b1, 8'hFF)},
			'{8'hF0, 1'b1, whole_atom(KIND_CTRL, 1'b0, 8'hF0)},
			'{8'hFF, 1'b1, whole_atom(KIND_CTRL, 1'b0, 8'hFF)},
			'{8'h80, 1'b1, whole_atom(KIND_SHORT, 1'b0, 8'h00)},
			'{8'hB2, 1'b0, '0},
			'{8'hAA, 1'b0, '0},
			'{8'h55, 1'b0, '0},
			'{8'hD8, 1'b0, '0},
			'{8'h00, 1'b0, '0},
			'{8'hE3, 1'b0, '0},
			'{8'h00, 1'b0, '0},
			'{8'h00, 1'b0, '0},
			'{8'h01, 1'b0, '0},
			'{8'h9C, 1'b0, '0},
			'{8'hEC, 1'b0, '0},
			'{8'h00, 1'b0, '0},
			'{8'h00, 1'b0, '0},
			'{8'h00, 1'b1, whole_atom(KIND_LONG, 1'b0, 8'h00)}
		};
		foreach (rows[i]) feed_byte(rows[i].stim, rows[i].typed, rows[i].res);

		// The output is held off while the input keeps offering, so both registers fill up.
		hold_requests++;
		feed_random_atoms(130);
		send_idle_pct = 67;
		feed_random_atoms(130);
		send_idle_pct = 0;
		recv_stall_pct = 67;
		feed_random_atoms(130);
		send_idle_pct = 27;
		recv_stall_pct = 27;
		feed_random_atoms(130);

		// The longest long atom, left open after a few bytes.
		feed_byte(8'hE2);
		repeat (3) feed_byte(8'hFF);
		repeat (16) feed_byte(8'($urandom));
		in_valid <= 1'b0;
		recv_stall_pct = 0;

		while (atom_results_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule
